// ----- rtl/nfsa_pkg.sv -----
// Shared types and constants for the next-fit slot allocator.
// Holds the transfer payload structs, command and status codes, and the FSM state type.
// No dependencies.
package nfsa_pkg;

	// Flag bitmap geometry: one memory word holds this many slot flags.
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;

	// Default pool depth and the pool count after reset.
	localparam int         POOL_DEPTH_DEF = 1024;
	localparam int         COUNT_W        = 11;
	localparam logic [10:0] POOL_COUNT_RST = 11'd1024;

	// Field widths fixed by the payload.
	localparam int INDEX_W = 10;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               command;
		logic [INDEX_W-1:0] free_index;
	} cmd_item_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] granted_index;
	} res_item_t;

	// Tag that travels with each word read during a search.
	typedef struct packed {
		logic first;   // first visit of the start word: only bits at or above the cursor
		logic rev;     // wrap-around revisit of the start word: only bits below the cursor
		logic last;    // last word of the search
	} scan_tag_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_SCAN,
		FSM_FREE_WR,
		FSM_DONE
	} fsm_t;

endpackage

// ----- rtl/nfsa_flag_ram.sv -----
// Flag bitmap storage for the slot allocator: one write port, one registered read port.
// Depends on nfsa_pkg for the word width.
module nfsa_flag_ram #(
	parameter int POOL_DEPTH = nfsa_pkg::POOL_DEPTH_DEF,
	parameter int WA_W       =
		((POOL_DEPTH + nfsa_pkg::WORD_W - 1) / nfsa_pkg::WORD_W > 1)
		? $clog2((POOL_DEPTH + nfsa_pkg::WORD_W - 1) / nfsa_pkg::WORD_W) : 1
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [WA_W-1:0]             rd_addr,
	output logic [nfsa_pkg::WORD_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [WA_W-1:0]             wr_addr,
	input  logic [nfsa_pkg::WORD_W-1:0] wr_data
);
	import nfsa_pkg::*;

	localparam int WORDS = (POOL_DEPTH + WORD_W - 1) / WORD_W;

	logic [WORD_W-1:0] mem [WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/nfsa_word_scan.sv -----
// Search unit of the slot allocator: masks one flag word and finds its lowest free slot.
// Depends on nfsa_pkg for the word geometry and the scan tag.
module nfsa_word_scan #(
	parameter int WA_W = 4,
	parameter int NW   = 11
) (
	input  logic [nfsa_pkg::WORD_W-1:0] data,
	input  logic [WA_W-1:0]             word,
	input  logic [NW-1:0]               count,
	input  logic [nfsa_pkg::BIT_W-1:0]  start_bit,
	input  nfsa_pkg::scan_tag_t         tag,
	output logic                        found,
	output logic [nfsa_pkg::BIT_W-1:0]  bit_idx
);
	import nfsa_pkg::*;

	logic [NW-BIT_W-1:0] word_ext;
	logic [NW-BIT_W-1:0] full_words;
	logic [WORD_W-1:0]   lim_mask;
	logic [WORD_W-1:0]   pos_mask;
	logic [WORD_W-1:0]   free_bits;

	assign word_ext   = (NW-BIT_W)'(word);
	assign full_words = count[NW-1:BIT_W];

	// Slots at or beyond the pool count are never candidates.
	always_comb begin
		if (word_ext < full_words) begin
			lim_mask = '1;
		end else if (word_ext == full_words) begin
			lim_mask = ~({WORD_W{1'b1}} << count[BIT_W-1:0]);
		end else begin
			lim_mask = '0;
		end
	end

	// The start word is split around the cursor between its first visit and its revisit.
	always_comb begin
		if (tag.first) begin
			pos_mask = {WORD_W{1'b1}} << start_bit;
		end else if (tag.rev) begin
			pos_mask = ~({WORD_W{1'b1}} << start_bit);
		end else begin
			pos_mask = '1;
		end
	end

	assign free_bits = ~data & lim_mask & pos_mask;
	assign found     = |free_bits;

	// Lowest free bit wins.
	always_comb begin
		bit_idx = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				bit_idx = BIT_W'(b);
			end
		end
	end

endmodule

// ----- rtl/next_fit_slot_allocator.sv -----
// Top level of the next-fit slot allocator: sequencer, cursor, pool count and result register.
// Depends on nfsa_pkg, nfsa_flag_ram and nfsa_word_scan.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  cmd     | in        | cmd_valid/cmd_stall | command, free_index
//  res     | out       | res_valid/res_stall | status, granted_index
//  cfg     | in        | cfg_we              | pool_count (cfg_data)
//
// An allocate reads 64-bit flag words, one word per cycle, through the single flag memory
// read port until a free slot is found, at most ceil(pool_count/64) + 1 words. A free reads
// its flag word, then modifies and writes it; a bad index or an empty pool goes straight to
// DONE. After reset a clearing pass writes every flag word with cmd_stall high; cfg writes
// are taken anytime. cmd_stall is high while an item is in work, also while a finished
// item waits in DONE for a held result to leave the result register.
module next_fit_slot_allocator #(
	parameter int POOL_DEPTH = nfsa_pkg::POOL_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  nfsa_pkg::cmd_item_t            cmd,
	output logic                           res_valid,
	input  logic                           res_stall,
	output nfsa_pkg::res_item_t            res,
	input  logic                           cfg_we,
	input  logic [nfsa_pkg::COUNT_W-1:0]   cfg_data
);
	import nfsa_pkg::*;

	localparam int WORDS   = (POOL_DEPTH + WORD_W - 1) / WORD_W;
	localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PADDR_W = WA_W + BIT_W;
	localparam int NW      = (COUNT_W > PADDR_W + 1) ? COUNT_W : PADDR_W + 1;
	localparam int WU_W    = WA_W + 1;

	fsm_t state_q, state_d;

	logic [COUNT_W-1:0] pool_count_q;
	logic [PADDR_W-1:0] cursor_q;
	logic [BIT_W-1:0]   start_bit_q;
	logic [WA_W-1:0]    rd_word_q;
	logic [WU_W-1:0]    iss_k_q;
	logic [WA_W-1:0]    clr_cnt_q;
	logic [PADDR_W-1:0] free_slot_q;
	res_item_t          pend_q;
	res_item_t          res_q;
	logic               res_valid_q;

	logic               vld_s1;
	logic [WA_W-1:0]    word_s1;
	scan_tag_t          tag_s1;

	logic [NW-1:0]      pc_ext;
	logic [NW-1:0]      n_eff;
	logic [NW-1:0]      n_round;
	logic [WU_W-1:0]    words_used;
	logic [WU_W-1:0]    visits;
	logic [NW-1:0]      cur_ext;
	logic [PADDR_W-1:0] start_slot;
	logic [NW-1:0]      idx_ext;
	logic               idx_bad;
	logic               cmd_xfer;
	logic               res_free;
	logic               issue;
	logic [WA_W-1:0]    next_word;

	logic               rd_en;
	logic [WA_W-1:0]    rd_addr;
	logic [WORD_W-1:0]  rd_data;
	logic               wr_en;
	logic [WA_W-1:0]    wr_addr;
	logic [WORD_W-1:0]  wr_data;

	logic               scan_found;
	logic [BIT_W-1:0]   scan_bit;
	logic [NW-1:0]      slot_ext;
	logic [NW-1:0]      slot_next;

	// Effective pool size and the number of flag words it spans.
	assign pc_ext     = NW'(pool_count_q);
	assign n_eff      = (pc_ext > NW'(POOL_DEPTH)) ? NW'(POOL_DEPTH) : pc_ext;
	assign n_round    = n_eff + NW'(WORD_W - 1);
	assign words_used = WU_W'(n_round >> BIT_W);
	assign visits     = words_used + WU_W'(start_bit_q != '0);

	// Search start and free index checks at the transfer.
	assign cur_ext    = NW'(cursor_q);
	assign start_slot = (cur_ext >= n_eff) ? '0 : cursor_q;
	assign idx_ext    = NW'(cmd.free_index);
	assign idx_bad    = idx_ext >= n_eff;

	assign cmd_xfer   = cmd_valid && !cmd_stall;
	assign res_free   = !res_valid_q || !res_stall;
	assign issue      = (iss_k_q < visits);
	assign next_word  = (WU_W'(rd_word_q) + WU_W'(1) == words_used) ? '0
	                    : rd_word_q + WA_W'(1);

	// Granted slot and the cursor just past it.
	assign slot_ext  = NW'({word_s1, scan_bit});
	assign slot_next = (slot_ext + NW'(1) >= n_eff) ? '0 : slot_ext + NW'(1);

	nfsa_flag_ram #(
		.POOL_DEPTH (POOL_DEPTH),
		.WA_W       (WA_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	nfsa_word_scan #(
		.WA_W (WA_W),
		.NW   (NW)
	) u_scan (
		.data      (rd_data),
		.word      (word_s1),
		.count     (n_eff),
		.start_bit (start_bit_q),
		.tag       (tag_s1),
		.found     (scan_found),
		.bit_idx   (scan_bit)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (clr_cnt_q == WA_W'(WORDS - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (cmd_xfer) begin
					if (cmd.command == CMD_FREE) begin
						state_d = idx_bad ? FSM_DONE : FSM_FREE_WR;
					end else begin
						state_d = (n_eff == '0) ? FSM_DONE : FSM_SCAN;
					end
				end
			end
			FSM_SCAN: begin
				if (vld_s1 && (scan_found || tag_s1.last)) begin
					state_d = FSM_DONE;
				end
			end
			FSM_FREE_WR: begin
				state_d = FSM_DONE;
			end
			FSM_DONE: begin
				if (res_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Memory port control and input stall.
	always_comb begin
		cmd_stall = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = rd_word_q;
		wr_en     = 1'b0;
		wr_addr   = word_s1;
		wr_data   = rd_data | (WORD_W'(1) << scan_bit);
		case (state_q)
			FSM_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
			end
			FSM_IDLE: begin
				cmd_stall = 1'b0;
				rd_en     = cmd_valid && (cmd.command == CMD_FREE);
				rd_addr   = idx_ext[PADDR_W-1:BIT_W];
			end
			FSM_SCAN: begin
				rd_en = issue;
				wr_en = vld_s1 && scan_found;
			end
			FSM_FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = free_slot_q[PADDR_W-1:BIT_W];
				wr_data = rd_data & ~(WORD_W'(1) << free_slot_q[BIT_W-1:0]);
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	// Control state: FSM, configuration, cursor, clear counter, issue counter, read tag valid, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_CLEAR;
			pool_count_q <= POOL_COUNT_RST;
			cursor_q     <= '0;
			clr_cnt_q    <= '0;
			iss_k_q      <= '0;
			vld_s1       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pool_count_q <= cfg_data;
			end
			if (state_q == FSM_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + WA_W'(1);
			end
			if (state_q == FSM_IDLE) begin
				iss_k_q <= '0;
				vld_s1  <= 1'b0;
			end else if (state_q == FSM_SCAN) begin
				// A found slot ends the search, so a read issued in the same cycle is dropped.
				vld_s1 <= issue && !(vld_s1 && scan_found);
				if (issue) begin
					iss_k_q <= iss_k_q + WU_W'(1);
				end
				if (vld_s1 && scan_found) begin
					cursor_q <= slot_next[PADDR_W-1:0];
				end
			end else begin
				vld_s1 <= 1'b0;
			end
			// The result register fills as the sequencer leaves DONE and empties on a transfer.
			if (state_q == FSM_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload and search bookkeeping.
	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && cmd_xfer) begin
			start_bit_q <= start_slot[BIT_W-1:0];
			rd_word_q   <= start_slot[PADDR_W-1:BIT_W];
			free_slot_q <= idx_ext[PADDR_W-1:0];
			pend_q.granted_index <= '0;
			if (cmd.command == CMD_FREE) begin
				pend_q.status <= idx_bad ? ST_BAD_INDEX : ST_OK;
			end else begin
				pend_q.status <= ST_FULL;
			end
		end
		if (state_q == FSM_SCAN) begin
			if (issue) begin
				rd_word_q    <= next_word;
				word_s1      <= rd_word_q;
				tag_s1.first <= (iss_k_q == '0);
				tag_s1.rev   <= (iss_k_q == words_used);
				tag_s1.last  <= (iss_k_q == visits - WU_W'(1));
			end
			if (vld_s1 && scan_found) begin
				pend_q.status        <= ST_OK;
				pend_q.granted_index <= slot_ext[INDEX_W-1:0];
			end
		end
		if (state_q == FSM_DONE && res_free) begin
			res_q <= pend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// No result leaves during the clearing pass.
	a_no_res_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_CLEAR) |-> !res_valid)
		else $error("result valid during the flag clearing pass");

	// A failed or free result never carries a granted slot.
	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ST_OK) |-> (res.granted_index == '0))
		else $error("granted index set on a non-ok result");

	// A command transfer always starts work, so the next cycle is not idle.
	a_xfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q != FSM_IDLE))
		else $error("command transfer did not start work");

	// A found slot ends the search in the next cycle.
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN && vld_s1 && scan_found) |=> (state_q == FSM_DONE))
		else $error("search continued after a free slot was found");

endmodule
